// ===== hdl/pid_pkg.sv =====
// Package for the priority interrupt dispatcher.
// Holds the payload structs, command and register codes and the sequencer state type.
// No dependencies; every other file of the block but pid_fifo imports it.
package pid_pkg;

	// Fixed field widths of the block's ports.
	localparam int SRC_W        = 2;
	localparam int MASK_W       = 4;
	localparam int PRIO_TABLE_W = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HANDLER  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRIORITY = 2'd2;

	// Queue depths, as address widths.
	localparam int JOB_ADDR_W = 1;
	localparam int RES_ADDR_W = 2;

	typedef enum logic {
		CMD_RAISE    = 1'b0,
		CMD_DISPATCH = 1'b1
	} pid_cmd_t;

	typedef struct packed {
		pid_cmd_t         cmd;
		logic [SRC_W-1:0] source_index;
	} pid_in_t;

	typedef struct packed {
		logic             found;
		logic [SRC_W-1:0] serviced_source;
		logic             handler_present;
		logic             last;
	} pid_out_t;

	// One classified command waiting between the front and the back.
	typedef struct packed {
		pid_cmd_t         kind;
		logic [SRC_W-1:0] source;
	} pid_job_t;

	typedef enum logic {
		ST_IDLE,
		ST_SERVICE
	} pid_state_t;

endpackage

// ===== hdl/priority_interrupt_dispatcher.sv =====
// Top level of the priority interrupt dispatcher.
// Depends on pid_pkg, pid_front, pid_back and pid_fifo.
//
// Usage: both sides look like queues. An input beat (item) is taken when push is
// high and full is low. A raise sets the pending bit of the named source and gives
// no result. A dispatch services every pending, enabled source one after another,
// smallest priority value first and lower index on a tie, clearing each pending bit
// and emitting one result beat per source; the final beat carries last. With
// nothing eligible a dispatch gives a single beat with found low and last high.
// Results wait in a four-entry queue: the oldest is on result while empty is low
// and leaves when pop is high.
// Timing: a beat waits in the two-entry job queue until the idle service
// sequencer takes it. A raise is applied as it is taken; a dispatch moves the
// sequencer into its service state, where it clears one source per cycle while
// the result queue is not full, until the final beat. Each result beat is
// registered in the result queue before it shows on the ports. When the
// receiver stops popping, the result queue fills, the sequencer waits, the job
// queue fills and full rises; nothing is lost.
// Reset clears the configuration registers, the pending bits and both queues.
// The configuration port writes one register per cycle with cfg_we high; write it
// only while no dispatch is in progress.
module priority_interrupt_dispatcher
	import pid_pkg::*;
#(
	parameter int NUM_SOURCES   = 4,
	parameter int PRIORITY_BITS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  pid_in_t               item,
	output logic                  full,
	output logic                  empty,
	input  logic                  pop,
	output pid_out_t              result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic     job_valid;
	logic     job_pop;
	pid_job_t job;
	logic     res_full;
	logic     res_push;
	pid_out_t res;

	// Front end: classification and the job queue.
	pid_front #(
		.NUM_SOURCES(NUM_SOURCES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.job_pop  (job_pop),
		.job_valid(job_valid),
		.job      (job)
	);

	// Back end: registers, pending bits and the service sequencer.
	pid_back #(
		.NUM_SOURCES  (NUM_SOURCES),
		.PRIORITY_BITS(PRIORITY_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.job_valid(job_valid),
		.job      (job),
		.job_pop  (job_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res)
	);

	// The result queue decouples the sequencer from the receiver.
	pid_fifo #(
		.DATA_W($bits(pid_out_t)),
		.ADDR_W(RES_ADDR_W)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wr_data(res),
		.full   (res_full),
		.pop    (pop),
		.rd_data(result),
		.empty  (empty)
	);

endmodule

// ===== hdl/pid_fifo.sv =====
// Small synchronous queue of flip-flops with a registered occupancy count.
// Depends on nothing; used for the job queue and the result queue.
module pid_fifo #(
	parameter int DATA_W = 8,
	parameter int ADDR_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] wr_data,
	output logic              full,
	input  logic              pop,
	output logic [DATA_W-1:0] rd_data,
	output logic              empty
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [ADDR_W-1:0] wr_ptr_q;
	logic [ADDR_W-1:0] rd_ptr_q;
	logic [ADDR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == (ADDR_W + 1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== hdl/pid_front.sv =====
// Front end of the dispatcher: accepts input beats, drops raises on absent sources
// and queues the rest as jobs. Depends on pid_pkg and pid_fifo.
module pid_front
	import pid_pkg::*;
#(
	parameter int NUM_SOURCES = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  pid_in_t  item,
	output logic     full,
	input  logic     job_pop,
	output logic     job_valid,
	output pid_job_t job
);

	pid_job_t job_in;
	logic     keep;
	logic     job_empty;

	// A raise on a source the block does not have changes nothing, so it is not queued.
	assign keep = (item.cmd == CMD_DISPATCH) || (int'(item.source_index) < NUM_SOURCES);

	assign job_in.kind   = item.cmd;
	assign job_in.source = item.source_index;

	pid_fifo #(
		.DATA_W($bits(pid_job_t)),
		.ADDR_W(JOB_ADDR_W)
	) u_job_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push && keep),
		.wr_data(job_in),
		.full   (full),
		.pop    (job_pop),
		.rd_data(job),
		.empty  (job_empty)
	);

	assign job_valid = !job_empty;

endmodule

// ===== hdl/pid_back.sv =====
// Back end of the dispatcher: configuration registers, pending bits and the service
// sequencer with its priority selection tree. Depends on pid_pkg.
module pid_back
	import pid_pkg::*;
#(
	parameter int NUM_SOURCES   = 4,
	parameter int PRIORITY_BITS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  job_valid,
	input  pid_job_t              job,
	output logic                  job_pop,
	input  logic                  res_full,
	output logic                  res_push,
	output pid_out_t              res
);

	localparam int SEL_W  = $clog2(NUM_SOURCES);
	localparam int LEAVES = 1 << SEL_W;
	localparam int PAD_W  = (LEAVES * PRIORITY_BITS > PRIO_TABLE_W) ?
		LEAVES * PRIORITY_BITS : PRIO_TABLE_W;

	pid_state_t              state_q, state_d;
	logic [NUM_SOURCES-1:0]  enable_q, handler_q, pending_q, pending_d;
	logic [PRIO_TABLE_W-1:0] prio_q;
	logic [NUM_SOURCES-1:0]  elig, best_hot, raise_hot, remaining;
	logic [LEAVES-1:0]       elig_pad;
	logic [PAD_W-1:0]        prio_flat;
	logic                    node_have [1:2*LEAVES-1];
	logic [SEL_W-1:0]        node_idx  [1:2*LEAVES-1];
	logic [PRIORITY_BITS-1:0] node_pri [1:2*LEAVES-1];
	logic                    left_wins;

	// Configuration registers; mask bits past the last source are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= '0;
			handler_q <= '0;
			prio_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ENABLE:   enable_q  <= NUM_SOURCES'(cfg_data[MASK_W-1:0]);
				REG_HANDLER:  handler_q <= NUM_SOURCES'(cfg_data[MASK_W-1:0]);
				REG_PRIORITY: prio_q    <= cfg_data[PRIO_TABLE_W-1:0];
				default: ;
			endcase
		end
	end

	// Selection tree: smallest priority wins, the left (lower index) child on a tie.
	always_comb begin
		elig      = pending_q & enable_q;
		elig_pad  = LEAVES'(elig);
		prio_flat = PAD_W'(prio_q);
		left_wins = 1'b0;
		for (int n = 0; n < LEAVES; n++) begin
			node_have[LEAVES+n] = elig_pad[n];
			node_idx[LEAVES+n]  = SEL_W'(n);
			node_pri[LEAVES+n]  = prio_flat[n*PRIORITY_BITS +: PRIORITY_BITS];
		end
		for (int n = LEAVES - 1; n >= 1; n--) begin
			left_wins = node_have[2*n] &&
				(!node_have[2*n+1] || (node_pri[2*n] <= node_pri[2*n+1]));
			node_have[n] = node_have[2*n] || node_have[2*n+1];
			node_idx[n]  = left_wins ? node_idx[2*n] : node_idx[2*n+1];
			node_pri[n]  = left_wins ? node_pri[2*n] : node_pri[2*n+1];
		end
		for (int i = 0; i < NUM_SOURCES; i++) begin
			best_hot[i]  = node_have[1] && (node_idx[1] == SEL_W'(i));
			raise_hot[i] = (int'(job.source) == i);
		end
		remaining = elig & ~best_hot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pending_q <= '0;
		end else begin
			state_q   <= state_d;
			pending_q <= pending_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pending_d = pending_q;
		job_pop   = 1'b0;
		res_push  = 1'b0;
		res       = '0;
		case (state_q)
			ST_IDLE: begin
				job_pop = job_valid;
				if (job_valid) begin
					if (job.kind == CMD_RAISE) begin
						pending_d = pending_q | raise_hot;
					end else begin
						state_d = ST_SERVICE;
					end
				end
			end
			ST_SERVICE: begin
				if (!res_full) begin
					res_push = 1'b1;
					if (node_have[1]) begin
						res.found           = 1'b1;
						res.serviced_source = SRC_W'(node_idx[1]);
						res.handler_present = |(handler_q & best_hot);
						res.last            = (remaining == '0);
						pending_d           = pending_q & ~best_hot;
						if (remaining == '0) begin
							state_d = ST_IDLE;
						end
					end else begin
						res.last = 1'b1;
						state_d  = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== hdl/pid_checker.sv =====
// Port-level checks for the priority interrupt dispatcher, bound to its top level.
// Depends on pid_pkg.
module pid_checker
	import pid_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     empty,
	input logic     pop,
	input pid_out_t result
);

	// A waiting result beat holds until it is popped.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result beat changed or vanished before it was popped");

	// An empty dispatch reports a single, all-zero, last beat.
	a_not_found_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.found) |->
		(result.last && !result.handler_present && (result.serviced_source == '0)))
		else $error("beat without a serviced source is malformed");

	// Within one dispatch the same source is never serviced twice in a row.
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !result.last) ##1 (pop && !empty) |->
		(result.found && (result.serviced_source != $past(result.serviced_source))))
		else $error("source serviced twice within one dispatch");

	// A beat that is not last always names a serviced source.
	a_non_last_found: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.last) |-> result.found)
		else $error("non-final beat without a serviced source");

endmodule

bind priority_interrupt_dispatcher pid_checker u_pid_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.empty (empty),
	.pop   (pop),
	.result(result)
);
